// File: rtl/pcfp_pkg.sv
// package: sizes, operation codes and the structs shared by the page tag store
`timescale 1ns / 1ps

package pcfp_pkg;

    localparam int SLOTS       = 8;
    localparam int PAGE_BITS   = 16;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int OP_W        = 2;
    localparam int PAGE_FIELD_W = 16;
    localparam int SLOT_FIELD_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_REQUEST = 2'd0,
        OP_DROP    = 2'd1,
        OP_CLEAR   = 2'd2
    } t_op;

    // search token that walks the row of slot cells
    typedef struct packed {
        logic                 active;
        logic [PAGE_BITS-1:0] page;
        logic                 found;
        logic [SLOT_W-1:0]    hit_slot;
        logic                 have_empty;
        logic [SLOT_W-1:0]    empty_slot;
        logic                 have_best;
        logic [PAGE_BITS-1:0] best_dist;
        logic [SLOT_W-1:0]    best_slot;
    } t_probe;

    // state update broadcast to every cell
    typedef struct packed {
        logic                 wr_en;
        logic                 drop_en;
        logic                 clr_all;
        logic [SLOT_W-1:0]    slot;
        logic [PAGE_BITS-1:0] page;
    } t_cmd;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
    } t_result;

endpackage

// File: rtl/pcfp_cell.sv
// one slot cell: holds a page tag and its valid bit, updates and forwards the search token
`timescale 1ns / 1ps

module pcfp_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pcfp_pkg::SLOT_W-1:0]   i_idx,
    input  pcfp_pkg::t_cmd                i_cmd,
    input  pcfp_pkg::t_probe              i_probe,
    output pcfp_pkg::t_probe              o_probe
);
    import pcfp_pkg::*;

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic                 n_valid;
    t_probe               r_probe;
    t_probe               n_probe;
    logic [PAGE_BITS-1:0] w_dist;
    logic                 w_sel;

    assign w_sel  = (i_cmd.slot == i_idx);
    assign w_dist = (r_page >= i_probe.page) ? (r_page - i_probe.page)
                                             : (i_probe.page - r_page);

    always_comb begin
        n_probe = i_probe;
        if (i_probe.active) begin
            if (r_valid && (r_page == i_probe.page) && !i_probe.found) begin
                n_probe.found    = 1'b1;
                n_probe.hit_slot = i_idx;
            end
            if (!r_valid && !i_probe.have_empty) begin
                n_probe.have_empty = 1'b1;
                n_probe.empty_slot = i_idx;
            end
            if (r_valid && (!i_probe.have_best || (w_dist > i_probe.best_dist))) begin
                n_probe.have_best = 1'b1;
                n_probe.best_dist = w_dist;
                n_probe.best_slot = i_idx;
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.clr_all) begin
            n_valid = 1'b0;
        end else if (i_cmd.drop_en && w_sel) begin
            n_valid = 1'b0;
        end else if (i_cmd.wr_en && w_sel) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && w_sel) begin
            r_page <= i_cmd.page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.active <= 1'b0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;

endmodule

// File: rtl/page_cache_farthest_page_replacement_core.sv
// top level: tag store of cached page numbers with farthest-page replacement
//
// input channel i_in_valid / o_in_ready carries an operation: request a page,
// drop one slot or clear all slots. only a request gives a result, on the
// output channel o_out_valid / i_out_ready as slot, hit and fill_needed.
// a request enters a row of eight slot cells and moves one cell per cycle;
// each cell checks for a match, an empty slot and the farthest page. when the
// token leaves the row, a miss installs the victim and the result is registered;
// o_out_valid rises and the input opens in the same cycle, unless the result
// goes to the hold register. one request is in the row at a time; drop and
// clear are applied at their transfer edge.
// a finished result waits in the output register while the next item is
// taken; if a second result finishes before the first is taken it waits
// in a hold register and no new item is taken until it moves out.
// reset empties every slot and drops any pending result; page tags are
// not cleared since they are read only behind their valid bits.
`timescale 1ns / 1ps

module page_cache_farthest_page_replacement_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [pcfp_pkg::OP_W-1:0]           i_operation,
    input  logic [pcfp_pkg::PAGE_FIELD_W-1:0]   i_page_number,
    input  logic [pcfp_pkg::SLOT_FIELD_W-1:0]   i_slot_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [pcfp_pkg::SLOT_FIELD_W-1:0]   o_slot,
    output logic                                o_hit,
    output logic                                o_fill_needed
);
    import pcfp_pkg::*;

    t_probe  w_chain [SLOTS+1];
    t_probe  w_exit;
    t_cmd    w_cmd;
    t_result w_res;
    logic    w_accept;
    logic    w_out_free;

    logic    r_inflight;
    logic    n_inflight;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result n_out;
    logic    r_hold_valid;
    logic    n_hold_valid;
    t_result r_hold;
    t_result n_hold;

    assign o_in_ready = !r_inflight && !r_hold_valid;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_exit     = w_chain[SLOTS];

    always_comb begin
        w_chain[0]            = '0;
        w_chain[0].active     = w_accept && (i_operation == OP_REQUEST);
        w_chain[0].page       = i_page_number[PAGE_BITS-1:0];
    end

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            pcfp_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (SLOT_W'(g)),
                .i_cmd   (w_cmd),
                .i_probe (w_chain[g]),
                .o_probe (w_chain[g+1])
            );
        end
    endgenerate

    // slot choice when the token leaves the row: the hit slot, else the victim
    always_comb begin
        w_res.hit = w_exit.found;
        if (w_exit.found) begin
            w_res.slot = w_exit.hit_slot;
        end else if (w_exit.have_empty) begin
            w_res.slot = w_exit.empty_slot;
        end else begin
            w_res.slot = w_exit.best_slot;
        end
    end

    always_comb begin
        w_cmd         = '0;
        w_cmd.wr_en   = w_exit.active && !w_exit.found;
        w_cmd.page    = w_exit.page;
        w_cmd.slot    = w_res.slot;
        if (w_accept) begin
            case (i_operation)
                OP_DROP: begin
                    w_cmd.drop_en = (int'(i_slot_index) < SLOTS);
                    w_cmd.slot    = i_slot_index[SLOT_W-1:0];
                end
                OP_CLEAR: begin
                    w_cmd.clr_all = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        if (r_hold_valid && w_out_free) begin
            n_out_valid  = 1'b1;
            n_out        = r_hold;
            n_hold_valid = 1'b0;
        end else if (w_exit.active) begin
            if (w_out_free) begin
                n_out_valid = 1'b1;
                n_out       = w_res;
            end else begin
                n_hold_valid = 1'b1;
                n_hold       = w_res;
            end
        end
    end

    always_comb begin
        n_inflight = r_inflight;
        if (w_exit.active) begin
            n_inflight = 1'b0;
        end else if (w_accept && (i_operation == OP_REQUEST)) begin
            n_inflight = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_inflight   <= n_inflight;
            r_out_valid  <= n_out_valid;
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_hold <= n_hold;
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot        = SLOT_FIELD_W'(r_out.slot);
    assign o_hit         = r_out.hit;
    assign o_fill_needed = !r_out.hit;

endmodule

// File: rtl/pcfp_checker.sv
// checker on the top-level ports, bound to the top level
`timescale 1ns / 1ps

module pcfp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic [pcfp_pkg::OP_W-1:0]           i_operation,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [pcfp_pkg::SLOT_FIELD_W-1:0]   o_slot,
    input logic                                o_hit,
    input logic                                o_fill_needed
);
    import pcfp_pkg::*;

    // fill flag is the inverse of hit on every result
    a_fill_vs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fill_needed == !o_hit))
        else $error("fill_needed does not mirror hit");

    // a request transfer closes the input
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_operation == OP_REQUEST)) |=> !o_in_ready)
        else $error("input open while a request is searching");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_slot) && $stable(o_hit)))
        else $error("stalled result changed");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind page_cache_farthest_page_replacement_core pcfp_checker u_pcfp_checker (.*);

// File: bench/testbench.sv
// testbench: directed and random page requests, drops and clears checked against a tag store predictor
`timescale 1ns / 1ps

module testbench;
    import pcfp_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int GAP_MAX   = 19;
    localparam int LONG_HOLD = 400;
    localparam int RANDOM_OPS = 725;

    typedef struct {
        logic [OP_W-1:0]         operation;
        logic [PAGE_FIELD_W-1:0] page_number;
        logic [SLOT_FIELD_W-1:0] slot_index;
        bit                      drain;
    } t_item;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    hit;
        logic                    fill_needed;
    } t_lookup;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [OP_W-1:0]         i_operation = OP_REQUEST;
    logic [PAGE_FIELD_W-1:0] i_page_number = '0;
    logic [SLOT_FIELD_W-1:0] i_slot_index = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [SLOT_FIELD_W-1:0] o_slot;
    logic                    o_hit;
    logic                    o_fill_needed;

    t_item   ops_to_send[$];
    t_lookup lookups_due[$];
    t_item   offered;

    logic [PAGE_BITS-1:0] tag_page [SLOTS];
    bit                   tag_valid [SLOTS];

    int ops_total = 0;
    int ops_accepted = 0;
    int failures = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int hold_left = 0;
    int lookups_seen = 0;

    page_cache_farthest_page_replacement_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_page_number (i_page_number),
        .i_slot_index  (i_slot_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_slot        (o_slot),
        .o_hit         (o_hit),
        .o_fill_needed (o_fill_needed)
    );

    always #6 i_clk = ~i_clk;

    function automatic void push_item(logic [OP_W-1:0] op, logic [PAGE_FIELD_W-1:0] page,
                                      logic [SLOT_FIELD_W-1:0] idx, bit drain);
        t_item it;
        it.operation   = op;
        it.page_number = page;
        it.slot_index  = idx;
        it.drain       = drain;
        ops_to_send.push_back(it);
    endfunction

    // apply one operation to the tag store copy, queue the lookup result for a request
    task automatic tag_store_apply(input t_item it);
        logic [PAGE_BITS-1:0] page;
        logic [PAGE_BITS-1:0] page_gap;
        logic [PAGE_BITS-1:0] best_gap;
        int                   victim;
        int                   best;
        bit                   found;
        t_lookup              res;
        page   = it.page_number[PAGE_BITS-1:0];
        found  = 1'b0;
        victim = -1;
        case (it.operation)
            OP_DROP: begin
                if (it.slot_index < SLOTS)
                    tag_valid[it.slot_index] = 1'b0;
            end
            OP_CLEAR: begin
                for (int i = 0; i < SLOTS; i++)
                    tag_valid[i] = 1'b0;
            end
            OP_REQUEST: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!found && tag_valid[i] && tag_page[i] == page) begin
                        found  = 1'b1;
                        victim = i;
                    end
                end
                if (!found) begin
                    for (int i = 0; i < SLOTS; i++)
                        if (victim < 0 && !tag_valid[i])
                            victim = i;
                    if (victim < 0) begin
                        best     = 0;
                        best_gap = '0;
                        for (int i = 0; i < SLOTS; i++) begin
                            page_gap = (tag_page[i] >= page) ? tag_page[i] - page
                                                             : page - tag_page[i];
                            if (i == 0 || page_gap > best_gap) begin
                                best     = i;
                                best_gap = page_gap;
                            end
                        end
                        victim = best;
                    end
                    tag_page[victim]  = page;
                    tag_valid[victim] = 1'b1;
                end
                res.slot        = victim[SLOT_FIELD_W-1:0];
                res.hit         = found;
                res.fill_needed = !found;
                lookups_due.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                tag_store_apply(offered);
                ops_accepted++;
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the payload until the transfer
            end else if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (ops_to_send.size() != 0 &&
                         !(ops_to_send[0].drain && lookups_due.size() != 0)) begin
                offered = ops_to_send.pop_front();
                i_in_valid    <= 1'b1;
                i_operation   <= offered.operation;
                i_page_number <= offered.page_number;
                i_slot_index  <= offered.slot_index;
                send_gap = (ops_accepted % 90 < 25) ? 0 : $urandom_range(0, GAP_MAX);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each transfer and drives the stalls, one long hold included
    always @(posedge i_clk) begin
        t_lookup want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_stall = 0;
            hold_left  = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                lookups_seen++;
                if (lookups_due.size() == 0) begin
                    $error("unexpected result: slot %0d hit %0d fill_needed %0d",
                           o_slot, o_hit, o_fill_needed);
                    failures++;
                end else begin
                    want = lookups_due.pop_front();
                    if (o_slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, o_slot);
                        failures++;
                    end
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_hit);
                        failures++;
                    end
                    if (o_fill_needed !== want.fill_needed) begin
                        $error("fill_needed: expected %0d, got %0d",
                               want.fill_needed, o_fill_needed);
                        failures++;
                    end
                end
                recv_stall = (lookups_seen % 70 < 20) ? 0 : $urandom_range(0, GAP_MAX);
                if (lookups_seen == 150)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [PAGE_FIELD_W-1:0] pool [12];
        logic [PAGE_FIELD_W-1:0] base;
        logic [PAGE_FIELD_W-1:0] page;
        logic [OP_W-1:0]         op;
        int                      counted;
        int                      pick;

        // directed: extremes, ignored code, drops, full store, equal distances
        push_item(OP_REQUEST, 16'h0000, 3'd0, 1'b0);
        push_item(OP_REQUEST, 16'hFFFF, 3'd7, 1'b0);
        push_item(OP_REQUEST, 16'h0000, 3'd0, 1'b0);
        push_item(OP_UNUSED,  16'hFFFF, 3'd7, 1'b0);
        push_item(OP_DROP,    16'h0000, 3'd1, 1'b0);
        push_item(OP_REQUEST, 16'h1234, 3'd0, 1'b0);
        push_item(OP_DROP,    16'hFFFF, 3'd5, 1'b0);
        push_item(OP_REQUEST, 16'h5555, 3'd0, 1'b0);
        push_item(OP_REQUEST, 16'hAAAA, 3'd0, 1'b0);
        push_item(OP_REQUEST, 16'h8000, 3'd0, 1'b0);
        push_item(OP_REQUEST, 16'h0001, 3'd0, 1'b0);
        push_item(OP_REQUEST, 16'h7FFF, 3'd0, 1'b0);
        push_item(OP_REQUEST, 16'hFFFE, 3'd0, 1'b0);
        push_item(OP_REQUEST, 16'h8000, 3'd0, 1'b0);
        push_item(OP_REQUEST, 16'h4000, 3'd0, 1'b0);
        push_item(OP_CLEAR,   16'h0000, 3'd0, 1'b0);
        push_item(OP_REQUEST, 16'd100,  3'd0, 1'b0);
        push_item(OP_REQUEST, 16'd300,  3'd0, 1'b0);
        push_item(OP_REQUEST, 16'd190,  3'd0, 1'b0);
        push_item(OP_REQUEST, 16'd210,  3'd0, 1'b0);
        push_item(OP_REQUEST, 16'd195,  3'd0, 1'b0);
        push_item(OP_REQUEST, 16'd205,  3'd0, 1'b0);
        push_item(OP_REQUEST, 16'd199,  3'd0, 1'b0);
        push_item(OP_REQUEST, 16'd201,  3'd0, 1'b0);
        push_item(OP_REQUEST, 16'd200,  3'd0, 1'b0);

        for (int i = 0; i < 12; i++)
            pool[i] = PAGE_FIELD_W'($urandom);
        base    = PAGE_FIELD_W'($urandom);
        counted = 0;
        while (counted < RANDOM_OPS) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                op = OP_UNUSED;
            else if (pick < 6)
                op = OP_CLEAR;
            else if (pick < 18)
                op = OP_DROP;
            else
                op = OP_REQUEST;
            pick = $urandom_range(0, 9);
            if (pick < 5)
                page = pool[$urandom_range(0, 11)];
            else if (pick < 8)
                page = base + PAGE_FIELD_W'($urandom_range(0, 63));
            else
                page = PAGE_FIELD_W'($urandom);
            if ($urandom_range(0, 19) == 0)
                pool[$urandom_range(0, 11)] = PAGE_FIELD_W'($urandom);
            if ($urandom_range(0, 99) == 0)
                base = PAGE_FIELD_W'($urandom);
            push_item(op, page, SLOT_FIELD_W'($urandom_range(0, 7)),
                      counted == 300 || counted == 600);
            if (op != OP_UNUSED)
                counted++;
        end
        ops_total = ops_to_send.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_accepted != ops_total || lookups_due.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (failures == 0 && lookups_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/pcfp_pkg.sv
rtl/pcfp_cell.sv
rtl/page_cache_farthest_page_replacement_core.sv
rtl/pcfp_checker.sv
bench/testbench.sv
